// ===== rtl/rmsp_pkg.sv =====
// ----------------------------------------------------------------------------
// rmsp_pkg
// Shared types and fixed widths for the running mean, deviation and peak block.
// ----------------------------------------------------------------------------
package rmsp_pkg;

    localparam int ACC_BITS       = 64;
    localparam int ITER_BITS      = 7;
    localparam int ROOT_BITS      = 32;
    localparam int ROOT_ITER_BITS = 6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DELTA,
        ST_DIV_MEAN,
        ST_MEAN,
        ST_MUL,
        ST_ACC,
        ST_START_Q,
        ST_DIV_Q,
        ST_START_ROOT,
        ST_ROOT,
        ST_OUT
    } rmsp_state_t;

    typedef struct packed {
        logic load;
        logic start_div_mean;
        logic mean_upd;
        logic mul;
        logic acc;
        logic start_div_q;
        logic start_root;
        logic out_load;
    } rmsp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic root_done;
    } rmsp_sts_t;

endpackage

// ===== rtl/rmsp_div.sv =====
// ----------------------------------------------------------------------------
// rmsp_div
// Restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rmsp_div
    import rmsp_pkg::*;
#(
    parameter int DVS_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [ACC_BITS-1:0]   dividend,
    input  logic [DVS_BITS-1:0]   divisor,
    input  logic [ITER_BITS-1:0]  iters,
    output logic [ACC_BITS-1:0]   quotient,
    output logic                  done
);

    logic [ACC_BITS-1:0]  q_reg, q_next;
    logic [DVS_BITS-1:0]  r_reg, r_next;
    logic [DVS_BITS-1:0]  d_reg, d_next;
    logic [ITER_BITS-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DVS_BITS:0]    rem_shift;
    logic [DVS_BITS:0]    rem_diff;
    logic                 ge;

    assign rem_shift = {r_reg, q_reg[ACC_BITS-1]};
    assign rem_diff  = rem_shift - {1'b0, d_reg};
    assign ge        = (rem_shift >= {1'b0, d_reg});

    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = iters;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            q_next   = {q_reg[ACC_BITS-2:0], ge};
            r_next   = ge ? rem_diff[DVS_BITS-1:0] : rem_shift[DVS_BITS-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == ITER_BITS'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign quotient = q_reg;
    assign done     = done_reg;

endmodule

// ===== rtl/rmsp_sqrt.sv =====
// ----------------------------------------------------------------------------
// rmsp_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module rmsp_sqrt
    import rmsp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [ACC_BITS-1:0]   radicand,
    output logic [ROOT_BITS-1:0]  root,
    output logic                  done
);

    logic [ACC_BITS-1:0]       x_reg, x_next;
    logic [ROOT_BITS+1:0]      rem_reg, rem_next;
    logic [ROOT_BITS-1:0]      root_reg, root_next;
    logic [ROOT_ITER_BITS-1:0] cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [ROOT_BITS+3:0]      rem_shift;
    logic [ROOT_BITS+3:0]      trial;
    logic [ROOT_BITS+3:0]      rem_diff;
    logic                      ge;

    assign rem_shift = {rem_reg, x_reg[ACC_BITS-1:ACC_BITS-2]};
    assign trial     = (ROOT_BITS+4)'({root_reg, 2'b01});
    assign rem_diff  = rem_shift - trial;
    assign ge        = (rem_shift >= trial);

    always_comb begin
        x_next    = x_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            x_next    = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = ROOT_ITER_BITS'(ROOT_BITS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            x_next    = {x_reg[ACC_BITS-3:0], 2'b00};
            rem_next  = ge ? rem_diff[ROOT_BITS+1:0] : rem_shift[ROOT_BITS+1:0];
            root_next = {root_reg[ROOT_BITS-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == ROOT_ITER_BITS'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

// ===== rtl/rmsp_dp.sv =====
// ----------------------------------------------------------------------------
// rmsp_dp
// Datapath: statistics state, Welford update, divider, root unit and output.
// ----------------------------------------------------------------------------
module rmsp_dp
    import rmsp_pkg::*;
#(
    parameter int SAMPLE_BITS = 24,
    parameter int COUNT_BITS  = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  rmsp_cmd_t                 cmd,
    output rmsp_sts_t                 sts,
    input  logic [SAMPLE_BITS-1:0]    in_sample,
    input  logic                      in_clear,
    output logic [COUNT_BITS-1:0]     out_count,
    output logic [SAMPLE_BITS-1:0]    out_mean,
    output logic [SAMPLE_BITS-2:0]    out_stdev,
    output logic [SAMPLE_BITS-1:0]    out_peak
);

    localparam logic [SAMPLE_BITS-2:0] DMAX = '1;

    logic [COUNT_BITS-1:0]  cnt_reg;
    logic [SAMPLE_BITS-1:0] mean_reg;
    logic [ACC_BITS-1:0]    q_reg;
    logic [SAMPLE_BITS-1:0] peak_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic                   delta_neg_reg;
    logic [SAMPLE_BITS:0]   delta_mag_reg;
    logic [ACC_BITS-1:0]    prod_reg;
    logic [COUNT_BITS-1:0]  out_count_reg;
    logic [SAMPLE_BITS-1:0] out_mean_reg;
    logic [SAMPLE_BITS-2:0] out_stdev_reg;
    logic [SAMPLE_BITS-1:0] out_peak_reg;

    logic [COUNT_BITS-1:0]  base_cnt;
    logic [SAMPLE_BITS-1:0] base_peak;
    logic [SAMPLE_BITS-1:0] in_mag;
    logic [SAMPLE_BITS:0]   delta_c;
    logic [SAMPLE_BITS:0]   delta_mag_c;
    logic [SAMPLE_BITS:0]   dev_c;
    logic [SAMPLE_BITS:0]   dev_mag_c;
    logic [SAMPLE_BITS:0]   quot_c;
    logic [SAMPLE_BITS:0]   step_c;
    logic [SAMPLE_BITS:0]   mean_sum_c;
    logic [ACC_BITS:0]      acc_sum_c;
    logic [ACC_BITS-1:0]    div_dividend;
    logic [ITER_BITS-1:0]   div_iters;
    logic [ACC_BITS-1:0]    div_quot;
    logic [ROOT_BITS-1:0]   root;
    logic [SAMPLE_BITS-2:0] stdev_c;

    assign base_cnt  = in_clear ? '0 : cnt_reg;
    assign base_peak = in_clear ? '0 : peak_reg;
    assign in_mag    = in_sample[SAMPLE_BITS-1] ? (~in_sample + 1'b1) : in_sample;

    assign delta_c     = {sample_reg[SAMPLE_BITS-1], sample_reg}
                       - {mean_reg[SAMPLE_BITS-1], mean_reg};
    assign delta_mag_c = delta_c[SAMPLE_BITS] ? (~delta_c + 1'b1) : delta_c;
    assign dev_c       = {sample_reg[SAMPLE_BITS-1], sample_reg}
                       - {mean_reg[SAMPLE_BITS-1], mean_reg};
    assign dev_mag_c   = dev_c[SAMPLE_BITS] ? (~dev_c + 1'b1) : dev_c;

    assign quot_c     = div_quot[SAMPLE_BITS:0];
    assign step_c     = delta_neg_reg ? (~quot_c + 1'b1) : quot_c;
    assign mean_sum_c = {mean_reg[SAMPLE_BITS-1], mean_reg} + step_c;
    assign acc_sum_c  = {1'b0, q_reg} + {1'b0, prod_reg};

    assign div_dividend = cmd.start_div_mean
                        ? (ACC_BITS'(delta_mag_c) << (ACC_BITS - SAMPLE_BITS - 1))
                        : q_reg;
    assign div_iters    = cmd.start_div_mean ? ITER_BITS'(SAMPLE_BITS + 1)
                                             : ITER_BITS'(ACC_BITS);

    assign stdev_c = (root > ROOT_BITS'(DMAX)) ? DMAX : root[SAMPLE_BITS-2:0];

    rmsp_div #(
        .DVS_BITS (COUNT_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.start_div_mean | cmd.start_div_q),
        .dividend (div_dividend),
        .divisor  (cnt_reg),
        .iters    (div_iters),
        .quotient (div_quot),
        .done     (sts.div_done)
    );

    rmsp_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.start_root),
        .radicand (div_quot),
        .root     (root),
        .done     (sts.root_done)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            mean_reg <= '0;
            q_reg    <= '0;
            peak_reg <= '0;
        end else if (cmd.load) begin
            cnt_reg  <= (&base_cnt) ? base_cnt : base_cnt + 1'b1;
            peak_reg <= (in_mag > base_peak) ? in_mag : base_peak;
            if (in_clear) begin
                mean_reg <= '0;
                q_reg    <= '0;
            end
        end else if (cmd.mean_upd) begin
            mean_reg <= mean_sum_c[SAMPLE_BITS-1:0];
        end else if (cmd.acc) begin
            q_reg <= acc_sum_c[ACC_BITS] ? '1 : acc_sum_c[ACC_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            sample_reg <= in_sample;
        end
        if (cmd.start_div_mean) begin
            delta_neg_reg <= delta_c[SAMPLE_BITS];
            delta_mag_reg <= delta_mag_c;
        end
        if (cmd.mul) begin
            prod_reg <= ACC_BITS'(delta_mag_reg * dev_mag_c);
        end
        if (cmd.out_load) begin
            out_count_reg <= cnt_reg;
            out_mean_reg  <= mean_reg;
            out_stdev_reg <= stdev_c;
            out_peak_reg  <= peak_reg;
        end
    end

    assign out_count = out_count_reg;
    assign out_mean  = out_mean_reg;
    assign out_stdev = out_stdev_reg;
    assign out_peak  = out_peak_reg;

endmodule

// ===== rtl/rmsp_ctrl.sv =====
// ----------------------------------------------------------------------------
// rmsp_ctrl
// Controller: sequences one request through the datapath and owns the handshakes.
// ----------------------------------------------------------------------------
module rmsp_ctrl
    import rmsp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    input  rmsp_sts_t sts,
    output rmsp_cmd_t cmd
);

    rmsp_state_t state_reg, state_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic        slot_free;

    assign slot_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_DELTA;
                end
            end
            ST_DELTA:      state_next = ST_DIV_MEAN;
            ST_DIV_MEAN: begin
                if (sts.div_done) begin
                    state_next = ST_MEAN;
                end
            end
            ST_MEAN:       state_next = ST_MUL;
            ST_MUL:        state_next = ST_ACC;
            ST_ACC:        state_next = ST_START_Q;
            ST_START_Q:    state_next = ST_DIV_Q;
            ST_DIV_Q: begin
                if (sts.div_done) begin
                    state_next = ST_START_ROOT;
                end
            end
            ST_START_ROOT: state_next = ST_ROOT;
            ST_ROOT: begin
                if (sts.root_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_DELTA:      cmd.start_div_mean = 1'b1;
            ST_MEAN:       cmd.mean_upd       = 1'b1;
            ST_MUL:        cmd.mul            = 1'b1;
            ST_ACC:        cmd.acc            = 1'b1;
            ST_START_Q:    cmd.start_div_q    = 1'b1;
            ST_START_ROOT: cmd.start_root     = 1'b1;
            ST_OUT:        cmd.out_load       = slot_free;
            default:       cmd = '0;
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

// ===== rtl/running_mean_stdev_peak.sv =====
// ----------------------------------------------------------------------------
// running_mean_stdev_peak
// Online count, mean, population standard deviation and peak of a sample stream.
// ----------------------------------------------------------------------------
// Each request on the s_ channel carries one signed sample in s_tdata and a
// clear flag in s_tuser that empties the statistics before the sample is added.
// Every request yields exactly one result on the m_ channel with the count, the
// mean, the standard deviation and the peak absolute sample since the last clear.
// One request is processed at a time: a new request is taken only once the
// result of the one before has been loaded into the output register. Most of
// the processing time goes to the bit-serial divider, which runs once for the
// mean step and once over the 64-bit square sum, and to the 32-step square
// root unit. s_tready is high while the block waits for a request, even when
// an earlier result is still held in the output register. If the receiver
// stalls, the result is held and the next request stops before loading its
// result until the register is free. Reset clears the statistics to zero and
// drops m_tvalid; the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module running_mean_stdev_peak
    import rmsp_pkg::*;
#(
    parameter int SAMPLE_BITS = 24,
    parameter int COUNT_BITS  = 16
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // Fields from bit 0: sample.
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]          s_tdata,
    // Fields from bit 0: clear.
    input  logic                                      s_tuser,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // Fields from bit 0: count, mean, stdev, peak.
    output logic [((COUNT_BITS+3*SAMPLE_BITS-1+7)/8)*8-1:0] m_tdata
);

    localparam int OUT_BITS   = COUNT_BITS + 3 * SAMPLE_BITS - 1;
    localparam int M_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

    rmsp_cmd_t              cmd;
    rmsp_sts_t              sts;
    logic [COUNT_BITS-1:0]  out_count;
    logic [SAMPLE_BITS-1:0] out_mean;
    logic [SAMPLE_BITS-2:0] out_stdev;
    logic [SAMPLE_BITS-1:0] out_peak;
    logic [OUT_BITS-1:0]    out_vec;

    rmsp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rmsp_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .in_sample (s_tdata[SAMPLE_BITS-1:0]),
        .in_clear  (s_tuser),
        .out_count (out_count),
        .out_mean  (out_mean),
        .out_stdev (out_stdev),
        .out_peak  (out_peak)
    );

    assign out_vec = {out_peak, out_stdev, out_mean, out_count};
    assign m_tdata = M_TDATA_W'(out_vec);

endmodule

// ===== rtl/rmsp_chk.sv =====
// ----------------------------------------------------------------------------
// rmsp_chk
// Port-level checks on the running statistics block, bound to its top level.
// ----------------------------------------------------------------------------
module rmsp_chk #(
    parameter int SAMPLE_BITS = 24,
    parameter int COUNT_BITS  = 16
) (
    input logic                                              aclk,
    input logic                                              aresetn,
    input logic                                              s_tvalid,
    input logic                                              s_tready,
    input logic                                              m_tvalid,
    input logic                                              m_tready,
    input logic [((COUNT_BITS+3*SAMPLE_BITS-1+7)/8)*8-1:0]   m_tdata
);

    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result request dropped while stalled");

    a_m_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result data changed while stalled");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while one is in progress");

    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[COUNT_BITS-1:0] != '0)
        else $error("result shows an empty count");

endmodule

bind running_mean_stdev_peak rmsp_chk #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
) u_rmsp_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/rmsp_checker.sv =====
// ----------------------------------------------------------------------------
// rmsp_checker
// Watches both channels of the running statistics block, keeps its own copy of
// the count, mean, squared-deviation sum and peak, and compares every result
// field by field against the oldest predicted one.
// ----------------------------------------------------------------------------
module rmsp_checker #(
    parameter int SAMPLE_BITS = 24,
    parameter int COUNT_BITS  = 16
) (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    input  logic                                            s_tvalid,
    input  logic                                            s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]                s_tdata,
    input  logic                                            s_tuser,
    input  logic                                            m_tvalid,
    input  logic                                            m_tready,
    input  logic [((COUNT_BITS+3*SAMPLE_BITS-1+7)/8)*8-1:0] m_tdata,
    output int                                              mismatches,
    output int                                              outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MEAN_LSB  = COUNT_BITS;
    localparam int STDEV_LSB = COUNT_BITS + SAMPLE_BITS;
    localparam int PEAK_LSB  = COUNT_BITS + 2*SAMPLE_BITS - 1;

    typedef struct packed {
        logic [COUNT_BITS-1:0]  count;
        logic [SAMPLE_BITS-1:0] mean;
        logic [SAMPLE_BITS-2:0] stdev;
        logic [SAMPLE_BITS-1:0] peak;
    } stats_t;

    logic [COUNT_BITS-1:0]  n_acc;
    longint                 mean_acc;
    logic [63:0]            sq_acc;
    logic [SAMPLE_BITS-1:0] peak_acc;

    stats_t expected_stats[$];
    int     bad_fields = 0;
    int     waiting = 0;
    int     result_no = 0;

    assign mismatches  = bad_fields;
    assign outstanding = waiting;

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        bad_fields++;
    endtask

    function automatic logic [63:0] floor_root(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int i = 31; i >= 0; i--) begin
            t = r | (64'd1 << i);
            if (t * t <= x) begin
                r = t;
            end
        end
        return r;
    endfunction

    task automatic absorb_sample(input logic [SAMPLE_BITS-1:0] raw, input logic clr,
                                 output stats_t r);
        longint      v;
        longint      delta;
        longint      dev;
        longint      n;
        logic [63:0] a;
        logic [63:0] delta_m;
        logic [63:0] dev_m;
        logic [63:0] prod;
        logic [63:0] root;
        logic [63:0] stdev_cap;
        stdev_cap = (64'd1 << (SAMPLE_BITS-1)) - 64'd1;
        v = $signed(raw);
        if (clr) begin
            n_acc    = '0;
            mean_acc = 0;
            sq_acc   = '0;
            peak_acc = '0;
        end
        a = (v < 0) ? -v : v;
        if (a > peak_acc) begin
            peak_acc = a[SAMPLE_BITS-1:0];
        end
        if (n_acc != '1) begin
            n_acc = n_acc + 1'b1;
        end
        n = n_acc;
        delta = v - mean_acc;
        mean_acc = mean_acc + delta / n;
        dev = v - mean_acc;
        delta_m = (delta < 0) ? -delta : delta;
        dev_m = (dev < 0) ? -dev : dev;
        if (delta_m != 0 && dev_m > 64'hFFFF_FFFF_FFFF_FFFF / delta_m) begin
            prod = 64'hFFFF_FFFF_FFFF_FFFF;
        end else begin
            prod = delta_m * dev_m;
        end
        if (sq_acc > 64'hFFFF_FFFF_FFFF_FFFF - prod) begin
            sq_acc = 64'hFFFF_FFFF_FFFF_FFFF;
        end else begin
            sq_acc = sq_acc + prod;
        end
        root = floor_root(sq_acc / n_acc);
        if (root > stdev_cap) begin
            root = stdev_cap;
        end
        r.count = n_acc;
        r.mean  = mean_acc[SAMPLE_BITS-1:0];
        r.stdev = root[SAMPLE_BITS-2:0];
        r.peak  = peak_acc;
    endtask

    always @(posedge aclk) begin : watch
        stats_t got;
        stats_t want;
        stats_t fresh;
        if (!aresetn) begin
            n_acc    = '0;
            mean_acc = 0;
            sq_acc   = '0;
            peak_acc = '0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.count = m_tdata[MEAN_LSB-1:0];
                got.mean  = m_tdata[STDEV_LSB-1:MEAN_LSB];
                got.stdev = m_tdata[PEAK_LSB-1:STDEV_LSB];
                got.peak  = m_tdata[PEAK_LSB+SAMPLE_BITS-1:PEAK_LSB];
                if (expected_stats.size() == 0) begin
                    report_mismatch($sformatf("result %h with no request pending", m_tdata));
                end else begin
                    want = expected_stats.pop_front();
                    waiting--;
                    if (got.count !== want.count) begin
                        report_mismatch($sformatf("result %0d count %0h, expected %0h",
                                                  result_no, got.count, want.count));
                    end
                    if (got.mean !== want.mean) begin
                        report_mismatch($sformatf("result %0d mean %0h, expected %0h",
                                                  result_no, got.mean, want.mean));
                    end
                    if (got.stdev !== want.stdev) begin
                        report_mismatch($sformatf("result %0d stdev %0h, expected %0h",
                                                  result_no, got.stdev, want.stdev));
                    end
                    if (got.peak !== want.peak) begin
                        report_mismatch($sformatf("result %0d peak %0h, expected %0h",
                                                  result_no, got.peak, want.peak));
                    end
                end
                result_no++;
            end
            if (s_tvalid && s_tready) begin
                absorb_sample(s_tdata[SAMPLE_BITS-1:0], s_tuser, fresh);
                expected_stats.push_back(fresh);
                waiting++;
            end
        end
    end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus for the running mean, deviation and peak block: a directed run over
// the sample extremes, clears and rounding corners, then random segments of
// samples with random gaps on the request side and random stalls on the
// result side. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_BITS = 24;
    localparam int COUNT_BITS  = 16;
    localparam int S_WIDTH     = ((SAMPLE_BITS+7)/8)*8;
    localparam int M_WIDTH     = ((COUNT_BITS+3*SAMPLE_BITS-1+7)/8)*8;
    localparam int RANDOM_ITEMS = 850;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [S_WIDTH-1:0] s_tdata = '0;
    logic               s_tuser = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [M_WIDTH-1:0] m_tdata;
    int                 mismatches;
    int                 outstanding;
    bit                 calm = 1'b0;
    int                 stall_left = 0;

    running_mean_stdev_peak #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    rmsp_checker #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .outstanding(outstanding)
    );

    initial forever #1 aclk = ~aclk;

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end else if (!calm && m_tready && $urandom_range(0, 99) < 3) begin
            stall_left = $urandom_range(1, 18) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic offer(input logic [SAMPLE_BITS-1:0] smp, input logic clr);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tuser  <= clr;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    initial begin : stimulus
        logic [SAMPLE_BITS-1:0] smp;
        logic [SAMPLE_BITS-1:0] base;
        logic [31:0]            word;
        logic                   clr;
        int                     spread;
        int                     ofs;
        int                     seg_left;
        int                     guard;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        offer(24'h000000, 1'b0);
        offer(24'h7FFFFF, 1'b0);
        offer(24'h800000, 1'b0);
        offer(24'h000001, 1'b0);
        offer(24'h800000, 1'b1);
        offer(24'h7FFFFF, 1'b0);
        offer(24'h800000, 1'b0);
        offer(24'h7FFFFF, 1'b0);
        offer(24'h800000, 1'b0);
        offer(24'h7FFFFF, 1'b0);
        offer(24'h000001, 1'b1);
        offer(24'hFFFFFF, 1'b0);
        offer(24'h000001, 1'b0);
        offer(24'hFFFFFB, 1'b1);
        offer(24'hFFFFFE, 1'b0);
        offer(24'h000000, 1'b0);
        offer(24'h000003, 1'b0);
        offer(24'h555555, 1'b1);
        offer(24'hAAAAAA, 1'b0);
        offer(24'hFFFFFF, 1'b0);
        offer(24'h000000, 1'b1);
        offer(24'h000000, 1'b0);

        seg_left = 0;
        base     = '0;
        spread   = 1;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            calm = (i >= RANDOM_ITEMS - 100);
            if (i == RANDOM_ITEMS / 2) begin
                s_tvalid <= 1'b0;
                @(negedge aclk);
                while (outstanding != 0) @(negedge aclk);
                @(posedge aclk);
            end
            clr = 1'b0;
            if (seg_left == 0) begin
                clr = ($urandom_range(0, 7) != 0);
                seg_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 400)
                                                       : $urandom_range(1, 40);
                word   = $urandom();
                base   = word[SAMPLE_BITS-1:0];
                spread = 1 << $urandom_range(0, 16);
            end
            seg_left--;
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    word = $urandom();
                    smp  = word[SAMPLE_BITS-1:0];
                end
                3: begin
                    case ($urandom_range(0, 4))
                        0: smp = 24'h7FFFFF;
                        1: smp = 24'h800000;
                        2: smp = 24'h800001;
                        3: smp = 24'hFFFFFF;
                        default: smp = 24'h000000;
                    endcase
                end
                default: begin
                    ofs = int'($urandom_range(0, 2*spread)) - spread;
                    smp = base + ofs[SAMPLE_BITS-1:0];
                end
            endcase
            offer(smp, clr);
        end
        s_tvalid <= 1'b0;

        guard = 0;
        while (outstanding != 0 && guard < 50_000) begin
            @(negedge aclk);
            guard++;
        end
        repeat (160) @(posedge aclk);
        if (outstanding != 0) begin
            $display("%0d results never arrived", outstanding);
        end
        if (mismatches == 0 && outstanding == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/rmsp_pkg.sv
rtl/rmsp_div.sv
rtl/rmsp_sqrt.sv
rtl/rmsp_dp.sv
rtl/rmsp_ctrl.sv
rtl/running_mean_stdev_peak.sv
rtl/rmsp_chk.sv
tb/rmsp_checker.sv
tb/tb.sv
